// ===== hw/rtl/prfmt_pkg.sv =====
`default_nettype none

package prfmt_pkg;

  // default widths
  localparam int VALUE_BITS_DEF = 32;
  localparam int COUNT_BITS_DEF = 32;

  // digit store of the conversion unit
  localparam int DIGIT_DEPTH = 10;
  localparam int DIGIT_IDX_W = $clog2(DIGIT_DEPTH);

  // request modes
  localparam logic [1:0] MODE_FMT = 2'd0;
  localparam logic [1:0] MODE_INT = 2'd1;
  localparam logic [1:0] MODE_STR = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_CHAR   = 2'd0;
  localparam logic [1:0] KIND_FINISH = 2'd1;
  localparam logic [1:0] KIND_ERR    = 2'd2;

  // pending conversions
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_STR  = 2'd1;
  localparam logic [1:0] PEND_DEC  = 2'd2;
  localparam logic [1:0] PEND_HEX  = 2'd3;

  // characters
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_S       = 8'h73;
  localparam logic [7:0] CH_D       = 8'h64;
  localparam logic [7:0] CH_X       = 8'h78;

  localparam int NULL_LEN = 6;

  // status of the conversion unit
  typedef struct packed {
    logic                   busy;
    logic [DIGIT_IDX_W-1:0] top_index;
  } digit_status_t;

  // lowercase hex digit character
  function automatic logic [7:0] hex_char(input logic [3:0] d);
    logic [7:0] c;
    case (d)
      4'd0:    c = 8'h30;
      4'd1:    c = 8'h31;
      4'd2:    c = 8'h32;
      4'd3:    c = 8'h33;
      4'd4:    c = 8'h34;
      4'd5:    c = 8'h35;
      4'd6:    c = 8'h36;
      4'd7:    c = 8'h37;
      4'd8:    c = 8'h38;
      4'd9:    c = 8'h39;
      4'd10:   c = 8'h61;
      4'd11:   c = 8'h62;
      4'd12:   c = 8'h63;
      4'd13:   c = 8'h64;
      4'd14:   c = 8'h65;
      default: c = 8'h66;
    endcase
    return c;
  endfunction

  // characters of the null string text
  function automatic logic [7:0] null_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = 8'h28;
      3'd1:    c = 8'h6e;
      3'd2:    c = 8'h75;
      3'd3:    c = 8'h6c;
      3'd4:    c = 8'h6c;
      default: c = 8'h29;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/prfmt_digit_unit.sv =====
`default_nettype none

module prfmt_digit_unit
  import prfmt_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic                   decimal,
  input  wire logic [VALUE_BITS-1:0]  value,
  input  wire logic [DIGIT_IDX_W-1:0] rd_index,
  output      logic [3:0]             rd_digit,
  output      digit_status_t          status
);

  localparam int CNT_W = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] work;
  logic [3:0]            digits [DIGIT_DEPTH];
  logic [3:0]            adjusted [DIGIT_DEPTH];
  logic                  carry;
  logic                  dec_mode;
  logic [CNT_W-1:0]      bit_cnt;
  logic [DIGIT_IDX_W-1:0] top_index;

  // add-3 correction for decimal, plain nibbles for hex
  always_comb begin
    for (int i = 0; i < DIGIT_DEPTH; i++) begin
      adjusted[i] = (dec_mode && digits[i] >= 4'd5) ? digits[i] + 4'd3 : digits[i];
    end
  end

  // bit counter, control only
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_cnt <= '0;
    end else if (start) begin
      bit_cnt <= CNT_W'(VALUE_BITS);
    end else if (bit_cnt != '0) begin
      bit_cnt <= bit_cnt - CNT_W'(1);
    end
  end

  // one bit of the value shifted into the digit store per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      work     <= value;
      dec_mode <= decimal;
      carry    <= 1'b0;
      for (int i = 0; i < DIGIT_DEPTH; i++) begin
        digits[i] <= 4'd0;
      end
    end else if (bit_cnt != '0) begin
      work      <= {work[VALUE_BITS-2:0], 1'b0};
      carry     <= carry | adjusted[DIGIT_DEPTH-1][3];
      digits[0] <= {adjusted[0][2:0], work[VALUE_BITS-1]};
      for (int i = 1; i < DIGIT_DEPTH; i++) begin
        digits[i] <= {adjusted[i][2:0], adjusted[i-1][3]};
      end
    end
  end

  // most significant digit to print; all ten once the value overflowed the store
  always_comb begin
    top_index = '0;
    for (int i = 1; i < DIGIT_DEPTH; i++) begin
      if (digits[i] != 4'd0) begin
        top_index = DIGIT_IDX_W'(i);
      end
    end
    if (carry) begin
      top_index = DIGIT_IDX_W'(DIGIT_DEPTH - 1);
    end
  end

  assign status.busy      = (bit_cnt != '0);
  assign status.top_index = top_index;
  assign rd_digit         = digits[rd_index];

endmodule

`default_nettype wire

// ===== hw/rtl/printf_d_s_x_formatter_unit.sv =====
`default_nettype none
// plain requests: the result is held in S_ONE, then written to the output register once it is free
// integer requests: converted in the shared shift/add-3 digit unit, then the top digit is
//   located and the digits go out one by one; a minus sign goes out during conversion
// requests: one at a time; the next request is taken
//   once the last result is in the output register, which holds it while that request is accepted
// reset: synchronous active high, clears state, counters and the output valid flag

module printf_d_s_x_formatter_unit
  import prfmt_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [39:0] s_tdata,   // byte_value, number_value
  input  wire logic [3:0]  s_tuser,   // mode[1:0], string_null, string_empty
  input  wire logic        s_tlast,   // string_last
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [39:0] m_tdata,   // out_byte, char_count
  output      logic [1:0]  m_tuser,   // out_kind
  output      logic        m_tlast    // run_last
);

  localparam int NW = (VALUE_BITS > 32) ? VALUE_BITS : 32;
  localparam int CW = (COUNT_BITS > 32) ? COUNT_BITS : 32;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ONE   = 3'd1;
  localparam logic [2:0] S_NULL  = 3'd2;
  localparam logic [2:0] S_SIGN  = 3'd3;
  localparam logic [2:0] S_CONV  = 3'd4;
  localparam logic [2:0] S_DIGIT = 3'd5;

  logic [2:0]             state, state_next;
  logic                   percent_seen, percent_seen_next;
  logic [1:0]             pending, pending_next;
  logic [COUNT_BITS-1:0]  written_count, written_count_next;
  logic [7:0]             hold_byte, hold_byte_next;
  logic [1:0]             hold_kind, hold_kind_next;
  logic [2:0]             null_idx, null_idx_next;
  logic [DIGIT_IDX_W-1:0] digit_idx, digit_idx_next;

  logic [7:0]  out_byte;
  logic [1:0]  out_kind;
  logic        out_last;
  logic [31:0] out_count;

  // request fields
  logic [1:0]  in_mode;
  logic [7:0]  in_byte;
  logic        in_null;
  logic        in_empty;
  logic [NW-1:0]         num_ext;
  logic [VALUE_BITS-1:0] num_cut;
  logic [VALUE_BITS-1:0] num_mag;
  logic                  num_neg;

  logic accept;
  logic slot_free;
  logic emit_go;
  logic [7:0] emit_byte;
  logic [1:0] emit_kind;
  logic       emit_last;
  logic [COUNT_BITS-1:0] count_inc;
  logic [CW-1:0]         emit_count_ext;

  logic          conv_start;
  logic          conv_decimal;
  logic [3:0]    rd_digit;
  digit_status_t dstat;

  assign in_mode  = s_tuser[1:0];
  assign in_null  = s_tuser[2];
  assign in_empty = s_tuser[3];
  assign in_byte  = s_tdata[7:0];
  assign num_ext  = NW'(s_tdata[39:8]);
  assign num_cut  = num_ext[VALUE_BITS-1:0];
  assign conv_decimal = (pending == PEND_DEC);
  assign num_neg  = conv_decimal && num_cut[VALUE_BITS-1];
  assign num_mag  = num_neg ? (~num_cut + VALUE_BITS'(1)) : num_cut;

  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign slot_free = !m_tvalid || m_tready;

  // shared digit conversion unit
  prfmt_digit_unit #(
    .VALUE_BITS(VALUE_BITS)
  ) u_digits (
    .clk     (clk),
    .rst     (rst),
    .start   (conv_start),
    .decimal (conv_decimal),
    .value   (num_mag),
    .rd_index(digit_idx),
    .rd_digit(rd_digit),
    .status  (dstat)
  );

  // result selection for the emitting states
  always_comb begin
    emit_byte = hold_byte;
    emit_kind = KIND_CHAR;
    emit_last = 1'b1;
    emit_go   = 1'b0;
    unique case (state)
      S_ONE: begin
        emit_byte = hold_byte;
        emit_kind = hold_kind;
        emit_go   = slot_free;
      end
      S_NULL: begin
        emit_byte = null_char(null_idx);
        emit_last = (null_idx == 3'(NULL_LEN - 1));
        emit_go   = slot_free;
      end
      S_SIGN: begin
        emit_byte = CH_MINUS;
        emit_last = 1'b0;
        emit_go   = slot_free;
      end
      S_DIGIT: begin
        emit_byte = hex_char(rd_digit);
        emit_last = (digit_idx == '0);
        emit_go   = slot_free;
      end
      default: begin
        emit_go = 1'b0;
      end
    endcase
  end

  // saturating character count
  assign count_inc = (written_count == {COUNT_BITS{1'b1}}) ? written_count
                                                           : written_count + COUNT_BITS'(1);
  assign emit_count_ext = (emit_kind == KIND_CHAR) ? CW'(count_inc) : CW'(written_count);

  // sequencer
  always_comb begin
    state_next         = state;
    percent_seen_next  = percent_seen;
    pending_next       = pending;
    written_count_next = written_count;
    hold_byte_next     = hold_byte;
    hold_kind_next     = hold_kind;
    null_idx_next      = null_idx;
    digit_idx_next     = digit_idx;
    conv_start         = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          hold_kind_next = KIND_CHAR;
          hold_byte_next = in_byte;
          if (in_mode == MODE_FMT && pending == PEND_NONE) begin
            if (in_byte == CH_NUL) begin
              percent_seen_next = 1'b0;
              hold_kind_next    = KIND_FINISH;
              hold_byte_next    = 8'd0;
              state_next        = S_ONE;
            end else if (percent_seen) begin
              percent_seen_next = 1'b0;
              case (in_byte)
                CH_S:       pending_next = PEND_STR;
                CH_D:       pending_next = PEND_DEC;
                CH_X:       pending_next = PEND_HEX;
                CH_PERCENT: state_next   = S_ONE;
                default:    state_next   = S_IDLE;
              endcase
            end else if (in_byte == CH_PERCENT) begin
              percent_seen_next = 1'b1;
            end else begin
              state_next = S_ONE;
            end
          end else if (in_mode == MODE_INT && (pending == PEND_DEC || pending == PEND_HEX)) begin
            conv_start   = 1'b1;
            pending_next = PEND_NONE;
            state_next   = num_neg ? S_SIGN : S_CONV;
          end else if (in_mode == MODE_STR && pending == PEND_STR) begin
            if (in_null) begin
              pending_next  = PEND_NONE;
              null_idx_next = '0;
              state_next    = S_NULL;
            end else begin
              if (!in_empty && in_byte != CH_NUL) begin
                state_next = S_ONE;
              end
              if (s_tlast) begin
                pending_next = PEND_NONE;
              end
            end
          end else begin
            hold_kind_next = KIND_ERR;
            hold_byte_next = 8'd0;
            state_next     = S_ONE;
          end
        end
      end
      S_ONE: begin
        if (emit_go) begin
          state_next = S_IDLE;
        end
      end
      S_NULL: begin
        if (emit_go) begin
          null_idx_next = null_idx + 3'd1;
          if (emit_last) begin
            state_next = S_IDLE;
          end
        end
      end
      S_SIGN: begin
        if (emit_go) begin
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        if (!dstat.busy) begin
          digit_idx_next = dstat.top_index;
          state_next     = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (emit_go) begin
          digit_idx_next = digit_idx - DIGIT_IDX_W'(1);
          if (emit_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // count follows each emitted result
    if (emit_go) begin
      if (emit_kind == KIND_CHAR) begin
        written_count_next = count_inc;
      end else if (emit_kind == KIND_FINISH) begin
        written_count_next = '0;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      percent_seen  <= 1'b0;
      pending       <= PEND_NONE;
      written_count <= '0;
    end else begin
      state         <= state_next;
      percent_seen  <= percent_seen_next;
      pending       <= pending_next;
      written_count <= written_count_next;
    end
  end

  // payload holding registers
  always_ff @(posedge clk) begin
    hold_byte <= hold_byte_next;
    hold_kind <= hold_kind_next;
    null_idx  <= null_idx_next;
    digit_idx <= digit_idx_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_byte  <= emit_byte;
      out_kind  <= emit_kind;
      out_last  <= emit_last;
      out_count <= emit_count_ext[31:0];
    end
  end

  assign m_tdata = {out_count, out_byte};
  assign m_tuser = out_kind;
  assign m_tlast = out_last;

`ifndef SYNTH
  // a new request is never taken while the digit unit still runs
  assert property (@(posedge clk) disable iff (rst) s_tready |-> !dstat.busy)
    else $error("request accepted while digit conversion busy");

  // a waiting percent never coexists with a pending argument
  assert property (@(posedge clk) disable iff (rst)
    percent_seen |-> (pending == PEND_NONE))
    else $error("percent seen with argument pending");

  // finishing a call clears the count
  assert property (@(posedge clk) disable iff (rst)
    (emit_go && emit_kind == KIND_FINISH) |=> (written_count == '0))
    else $error("count not cleared after finish");

  // digits are read only once the conversion has completed
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DIGIT) |-> !dstat.busy)
    else $error("digit read during conversion");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import prfmt_pkg::*;

  // mode value that no request may carry
  localparam logic [1:0] MODE_BAD = 2'd3;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int ITEM_TARGET  = 230;
  localparam int DRAIN_CYCLES = 100;

  // one expected output character or status word
  typedef struct packed {
    logic [7:0]  ch;
    logic [1:0]  kind;
    logic        run_end;
    logic [31:0] count;
  } fmt_out_t;

  // formatter state mirror and queue of the characters it should emit
  class fmt_scoreboard;
    fmt_out_t    expected_out[$];
    bit          percent_open = 1'b0;
    logic [1:0]  conv_wait    = PEND_NONE;
    logic [31:0] call_chars   = '0;
    int          errors       = 0;

    function void emit(logic [7:0] ch, logic [1:0] kind);
      fmt_out_t r;
      if (kind == KIND_CHAR && call_chars != '1) call_chars++;
      r.ch      = (kind == KIND_CHAR) ? ch : CH_NUL;
      r.kind    = kind;
      r.run_end = 1'b0;
      r.count   = call_chars;
      expected_out.push_back(r);
    endfunction

    // sign, then digits from the most significant down
    function void emit_number(logic [31:0] raw, bit decimal);
      string       digit_chars;
      logic [3:0]  digits [10];
      logic [31:0] mag;
      logic [31:0] base;
      int          n;
      digit_chars = "0123456789abcdef";
      base = decimal ? 32'd10 : 32'd16;
      mag  = raw;
      n    = 0;
      if (decimal && raw[31]) begin
        mag = -raw;
        emit(CH_MINUS, KIND_CHAR);
      end
      do begin
        digits[n] = 4'(mag % base);
        n++;
        mag = mag / base;
      end while (mag != 0 && n < 10);
      while (n > 0) begin
        n--;
        emit(digit_chars[digits[n]], KIND_CHAR);
      end
    endfunction

    function void log_request(logic [1:0] mode, logic [7:0] ch, logic [31:0] num,
                              bit is_last, bit str_null, bit str_empty);
      int    first;
      string null_text;
      first     = expected_out.size();
      null_text = "(null)";
      if (mode == MODE_FMT && conv_wait == PEND_NONE) begin
        if (ch == CH_NUL) begin
          percent_open = 1'b0;
          emit(CH_NUL, KIND_FINISH);
          call_chars = '0;
        end else if (percent_open) begin
          percent_open = 1'b0;
          case (ch)
            CH_S:       conv_wait = PEND_STR;
            CH_D:       conv_wait = PEND_DEC;
            CH_X:       conv_wait = PEND_HEX;
            CH_PERCENT: emit(CH_PERCENT, KIND_CHAR);
            default:    ;
          endcase
        end else if (ch == CH_PERCENT) begin
          percent_open = 1'b1;
        end else begin
          emit(ch, KIND_CHAR);
        end
      end else if (mode == MODE_INT && (conv_wait == PEND_DEC || conv_wait == PEND_HEX)) begin
        emit_number(num, conv_wait == PEND_DEC);
        conv_wait = PEND_NONE;
      end else if (mode == MODE_STR && conv_wait == PEND_STR) begin
        if (str_null) begin
          for (int i = 0; i < NULL_LEN; i++) emit(null_text[i], KIND_CHAR);
          conv_wait = PEND_NONE;
        end else begin
          if (!str_empty && ch != CH_NUL) emit(ch, KIND_CHAR);
          if (is_last) conv_wait = PEND_NONE;
        end
      end else begin
        emit(CH_NUL, KIND_ERR);
      end
      if (expected_out.size() > first) expected_out[expected_out.size()-1].run_end = 1'b1;
    endfunction

    function void check_output(logic [7:0] ch, logic [1:0] kind, logic run_end,
                               logic [31:0] count);
      fmt_out_t want;
      if (expected_out.size() == 0) begin
        $error("unexpected result: out_byte %0h out_kind %0d", ch, kind);
        errors++;
        return;
      end
      want = expected_out.pop_front();
      if (ch !== want.ch) begin
        $error("out_byte: expected %0h, actual %0h", want.ch, ch);
        errors++;
      end
      if (kind !== want.kind) begin
        $error("out_kind: expected %0d, actual %0d", want.kind, kind);
        errors++;
      end
      if (run_end !== want.run_end) begin
        $error("run_last: expected %0d, actual %0d", want.run_end, run_end);
        errors++;
      end
      if (count !== want.count) begin
        $error("char_count: expected %0d, actual %0d", want.count, count);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic [3:0]  s_tuser;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  fmt_scoreboard sb;
  int            items_sent = 0;
  int            cycles = 0;
  bit            calm = 1'b0;
  int            hold = 0;

  printf_d_s_x_formatter_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial forever #5 clk = ~clk;

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // random single-bit flag
  function automatic bit pick_flag();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [31:0] pick_number();
    case ($urandom_range(0, 6))
      0:       return 32'd0;
      1:       return $urandom_range(0, 99);
      2:       return 32'h8000_0000;
      3:       return 32'h7fff_ffff;
      4:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_literal();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == CH_PERCENT);
    return c;
  endfunction

  // drive one request and wait for the handshake
  task automatic send_item(logic [1:0] mode, logic [7:0] ch, logic [31:0] num,
                           bit is_last, bit str_null, bit str_empty);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {num, ch};
    s_tuser  <= {str_empty, str_null, mode};
    s_tlast  <= is_last;
    do @(posedge clk); while (!s_tready);
    sb.log_request(mode, ch, num, is_last, str_null, str_empty);
    items_sent++;
  endtask

  // unused fields carry random bits
  task automatic put_fmt(logic [7:0] ch);
    send_item(MODE_FMT, ch, $urandom, pick_flag(), pick_flag(), pick_flag());
  endtask

  task automatic put_int(logic [31:0] num);
    send_item(MODE_INT, 8'($urandom), num, pick_flag(), pick_flag(), pick_flag());
  endtask

  task automatic put_str(logic [7:0] ch, bit is_last, bit str_null, bit str_empty);
    send_item(MODE_STR, ch, $urandom, is_last, str_null, str_empty);
  endtask

  task automatic put_conv(logic [7:0] ch);
    put_fmt(CH_PERCENT);
    put_fmt(ch);
  endtask

  task automatic put_string_arg();
    int len;
    if ($urandom_range(0, 9) == 0) begin
      put_str(8'($urandom), pick_flag(), 1'b1, pick_flag());
    end else begin
      len = $urandom_range(1, 4);
      for (int k = 0; k < len; k++)
        put_str(($urandom_range(0, 7) == 0) ? CH_NUL : 8'($urandom_range(1, 255)),
                k == len - 1, 1'b0, $urandom_range(0, 7) == 0);
    end
  endtask

  // one well-formed call with random content, sometimes broken
  task automatic run_call();
    int         pieces;
    logic [7:0] c;
    pieces = $urandom_range(1, 8);
    repeat (pieces) begin
      case ($urandom_range(0, 9))
        0, 1: put_fmt(pick_literal());
        2:    put_conv(CH_PERCENT);
        3: begin
          put_conv(CH_D);
          put_int(pick_number());
        end
        4: begin
          put_conv(CH_X);
          put_int(pick_number());
        end
        5, 6: begin
          put_conv(CH_S);
          put_string_arg();
        end
        7: begin
          do c = 8'($urandom_range(1, 255));
          while (c == CH_S || c == CH_D || c == CH_X || c == CH_PERCENT);
          put_conv(c);
        end
        8: begin
          case ($urandom_range(0, 2))
            0:       put_int($urandom);
            1:       put_str(8'($urandom), pick_flag(), pick_flag(), pick_flag());
            default: send_item(MODE_BAD, 8'($urandom), $urandom, pick_flag(),
                               pick_flag(), pick_flag());
          endcase
        end
        default: begin
          // format byte while an integer is awaited
          put_conv(CH_D);
          put_fmt(pick_literal());
          put_int(pick_number());
        end
      endcase
    end
    if ($urandom_range(0, 7) == 0) put_fmt(CH_PERCENT);
    put_fmt(CH_NUL);
  endtask

  // result side: random stalls
  initial begin
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        m_tready <= 1'b0;
        hold--;
      end else begin
        m_tready <= 1'b1;
        hold = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      end
    end
  end

  // compare each accepted result
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_output(m_tdata[7:0], m_tuser, m_tlast, m_tdata[39:8]);
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    sb       = new();
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    s_tlast  = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, every conversion and the corner cases
    put_fmt(8'hff);
    put_fmt(8'h01);
    put_conv(CH_PERCENT);
    put_conv(CH_D);
    put_int(32'h8000_0000);
    put_conv(CH_X);
    put_int(32'hffff_ffff);
    put_conv(CH_D);
    put_int(32'd0);
    put_conv(8'h71);
    put_conv(CH_S);
    put_str(8'h41, 1'b0, 1'b1, 1'b0);
    put_conv(CH_S);
    put_str(CH_NUL, 1'b0, 1'b0, 1'b0);
    put_str(8'hfe, 1'b0, 1'b0, 1'b1);
    put_str(8'h7a, 1'b0, 1'b0, 1'b0);
    put_str(8'h00, 1'b1, 1'b0, 1'b1);
    put_int(32'h1234_5678);
    put_str(8'h61, 1'b1, 1'b0, 1'b0);
    send_item(MODE_BAD, 8'hff, 32'hffff_ffff, 1'b1, 1'b1, 1'b1);
    put_conv(CH_D);
    put_fmt(8'h62);
    put_int(32'h7fff_ffff);
    put_fmt(CH_NUL);
    put_fmt(CH_PERCENT);
    put_fmt(CH_NUL);

    // random calls with some noise between them
    while (items_sent < ITEM_TARGET) begin
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0)
        send_item(2'($urandom_range(0, 3)), 8'($urandom), $urandom, pick_flag(),
                  pick_flag(), pick_flag());
      else
        run_call();
    end
    calm = 1'b0;
    @(negedge clk);
    s_tvalid <= 1'b0;

    // drain, then allow for late extra results
    while (sb.expected_out.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/prfmt_pkg.sv
hw/rtl/prfmt_digit_unit.sv
hw/rtl/printf_d_s_x_formatter_unit.sv
sim/tb_top.sv
